// ===== hw/rtl/swm_pkg.sv =====
// shared types and constants for the sliding window median filter
`default_nettype none

package swm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int WS_W     = 5;
  localparam logic [WS_W-1:0] WS_RESET = 5'd3;

  // what a cell tells its neighbors about its entry for the current request
  typedef struct packed {
    logic keep;      // entry survives this request
    logic d;         // an entry to the left of this one is dropped
    logic le;        // entry is not greater than the new sample
    logic drop_out;  // a drop happened at or left of this cell
  } cell_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/swm_cell.sv =====
// one cell of the sorted window: holds one entry and its age
`default_nettype none

module swm_cell
  import swm_pkg::*;
#(
  parameter int AW = 4
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        en,
  input  wire                        cfg_clear,
  input  wire                        seq_clear,
  input  wire                        drop_en,
  input  wire [AW-1:0]               k_last,
  input  wire signed [SAMPLE_W-1:0]  sample,
  input  wire                        drop_in,
  input  wire                        new_valid,
  input  wire cell_flags_t           left_flags,
  input  wire signed [SAMPLE_W-1:0]  left_val,
  input  wire [AW-1:0]               left_age,
  input  wire cell_flags_t           right_flags,
  input  wire signed [SAMPLE_W-1:0]  right_val,
  input  wire [AW-1:0]               right_age,
  output cell_flags_t                flags,
  output logic signed [SAMPLE_W-1:0] val,
  output logic [AW-1:0]              age,
  output logic                       vld,
  output logic signed [SAMPLE_W-1:0] val_next
);

  logic [AW-1:0] age_next;
  logic          my_drop;
  logic          from_right;
  logic          from_self;
  logic          from_left;

  always_comb begin
    my_drop        = vld && !seq_clear && drop_en && (age == k_last);
    flags.keep     = vld && !seq_clear && !my_drop;
    flags.d        = drop_in;
    flags.le       = flags.keep && (val <= sample);
    flags.drop_out = drop_in | my_drop;

    from_right = right_flags.keep && right_flags.d && right_flags.le;
    from_self  = flags.keep && (drop_in != flags.le);
    from_left  = left_flags.keep && !left_flags.d && !left_flags.le;

    // a slot that no old entry lands in takes the new sample
    if (from_right) begin
      val_next = right_val;
      age_next = right_age + 1'b1;
    end else if (from_self) begin
      val_next = val;
      age_next = age + 1'b1;
    end else if (from_left) begin
      val_next = left_val;
      age_next = left_age + 1'b1;
    end else begin
      val_next = sample;
      age_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= new_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && new_valid) begin
      val <= val_next;
      age <= age_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sliding_window_median.sv =====
// Running median filter over the last k samples (k = window_size, 1..WINDOW_MAX,
// 0 reads as 1, larger values saturate). The window is a row of WINDOW_MAX cells
// kept in ascending order; on each request every cell drops, keeps or shifts its
// entry by one place in the same cycle, so one sample is taken every clock.
// The lower median appears on the master side in the cycle after the request, from
// an output register; the slave side stalls only while that register is full and
// not taken. No result is produced until k samples have been seen since reset, a
// window_size write or a sample with new_sequence set.
`default_nettype none

module sliding_window_median
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX = 16
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_we,
  input  wire [WS_W-1:0]    cfg_wdata,  // window_size
  input  wire               s_tvalid,
  output logic              s_tready,
  input  wire [31:0]        s_tdata,    // [31:0] sample
  input  wire [0:0]         s_tuser,    // [0] new_sequence
  output logic              m_tvalid,
  input  wire               m_tready,
  output logic [31:0]       m_tdata     // [31:0] median
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int KW = $clog2(WINDOW_MAX + 1);

  logic [WS_W-1:0]            window_size;
  logic [KW-1:0]              fill_count;
  logic [KW-1:0]              fill_next;
  logic [KW-1:0]              fill_eff;
  logic [KW-1:0]              k;
  logic [31:0]                k32;
  logic [AW-1:0]              k_last;
  logic [AW-1:0]              mid;
  logic                       accept;
  logic                       seq_clear;
  logic                       full;
  logic                       emit;
  logic signed [SAMPLE_W-1:0] sample;

  cell_flags_t                flags    [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] vals     [WINDOW_MAX];
  logic signed [SAMPLE_W-1:0] vals_nxt [WINDOW_MAX];
  logic [AW-1:0]              ages     [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]      vld_vec;

  assign sample    = s_tdata;
  assign seq_clear = s_tuser[0];
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    if (window_size == '0) begin
      k32 = 32'd1;
    end else if (32'(window_size) > 32'(WINDOW_MAX)) begin
      k32 = 32'(WINDOW_MAX);
    end else begin
      k32 = 32'(window_size);
    end
    k      = k32[KW-1:0];
    k_last = AW'(k32 - 32'd1);
    mid    = AW'((k32 - 32'd1) >> 1);

    fill_eff  = seq_clear ? '0 : fill_count;
    full      = (fill_eff == k);
    fill_next = full ? k : fill_eff + 1'b1;
    emit      = (fill_next == k);
  end

  genvar i;
  generate
    for (i = 0; i < WINDOW_MAX; i++) begin : g_cell
      cell_flags_t                lf;
      cell_flags_t                rf;
      logic signed [SAMPLE_W-1:0] lv;
      logic signed [SAMPLE_W-1:0] rv;
      logic [AW-1:0]              la;
      logic [AW-1:0]              ra;
      logic                       din;

      if (i == 0) begin : g_left_edge
        assign lf  = '0;
        assign lv  = '0;
        assign la  = '0;
        assign din = 1'b0;
      end else begin : g_left
        assign lf  = flags[i-1];
        assign lv  = vals[i-1];
        assign la  = ages[i-1];
        assign din = flags[i-1].drop_out;
      end

      if (i == WINDOW_MAX - 1) begin : g_right_edge
        assign rf = '0;
        assign rv = '0;
        assign ra = '0;
      end else begin : g_right
        assign rf = flags[i+1];
        assign rv = vals[i+1];
        assign ra = ages[i+1];
      end

      swm_cell #(.AW(AW)) u_cell (
        .clk         (clk),
        .rst         (rst),
        .en          (accept),
        .cfg_clear   (cfg_we),
        .seq_clear   (seq_clear),
        .drop_en     (full),
        .k_last      (k_last),
        .sample      (sample),
        .drop_in     (din),
        .new_valid   (fill_next > KW'(i)),
        .left_flags  (lf),
        .left_val    (lv),
        .left_age    (la),
        .right_flags (rf),
        .right_val   (rv),
        .right_age   (ra),
        .flags       (flags[i]),
        .val         (vals[i]),
        .age         (ages[i]),
        .vld         (vld_vec[i]),
        .val_next    (vals_nxt[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WS_RESET;
      fill_count  <= '0;
    end else if (cfg_we) begin
      window_size <= cfg_wdata;
      fill_count  <= '0;
    end else if (accept) begin
      fill_count <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      m_tdata <= vals_nxt[mid];
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= k) else $error("fill count above window size");

  a_fill_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(vld_vec) == 32'(fill_count)) else $error("valid cells disagree with fill");

  a_vld_prefix: assert property (@(posedge clk) disable iff (rst)
    ((vld_vec + 1'b1) & vld_vec) == '0) else $error("valid cells not contiguous");

  a_full_emits: assert property (@(posedge clk) disable iff (rst)
    accept && !seq_clear && (fill_count == k) |=> m_tvalid)
    else $error("full window gave no median");
`endif

endmodule

`default_nettype wire

// ===== verif/sliding_window_median_tb.sv =====
// testbench for the sliding window median filter: directed table, then random phases
`timescale 1ns / 100ps

module sliding_window_median_tb
  import swm_pkg::*;
();

  localparam int WINDOW_MAX = 16;
  localparam int DRAIN_CYCLES = 6;
  localparam int STALL_LIMIT = 500;
  localparam int PHASE_ITEMS = 140;
  localparam int NUM_PHASES = 12;

  localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S_MIN = 32'h8000_0000;
  localparam logic [31:0] S_NEG1 = 32'hFFFF_FFFF;

  typedef struct {
    bit              do_cfg;
    logic [WS_W-1:0] cfg_val;
    logic [31:0]     smp;
    bit              new_seq;
    bit              typed;
    logic [31:0]     known_med;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [WS_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;

  sliding_window_median #(.WINDOW_MAX(WINDOW_MAX)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // [31:0] sample
    .s_tuser   (s_tuser),   // [0] new_sequence
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)    // [31:0] median
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // window model
  logic [WS_W-1:0]     win_size_reg = WS_RESET;
  logic signed [31:0]  win_vals [WINDOW_MAX];
  logic [3:0]          win_ages [WINDOW_MAX];
  int                  win_fill = 0;

  logic [31:0] expected_medians [$];
  stim_row_t   directed_rows [$];

  bit no_idle = 1'b0;
  int errors = 0;
  int n_samples = 0;
  int n_medians = 0;
  int n_settings = 0;
  int idle_cycles = 0;

  function automatic void clear_window();
    for (int i = 0; i < WINDOW_MAX; i++) begin
      win_vals[i] = '0;
      win_ages[i] = '0;
    end
    win_fill = 0;
  endfunction

  // push the sample into the window, return 1 with the lower median once full
  function automatic bit slide_window(input logic signed [31:0] smp, input bit new_seq,
                                      output logic [31:0] med);
    int k;
    int i;
    int pos;
    k = (win_size_reg == 0) ? 1 : ((win_size_reg > WINDOW_MAX) ? WINDOW_MAX : win_size_reg);
    med = '0;
    if (new_seq) win_fill = 0;
    if (win_fill > k) win_fill = k;
    if (win_fill == k) begin
      i = 0;
      while (i < win_fill && win_ages[i] != k - 1) i++;
      if (i < win_fill) begin
        for (; i + 1 < win_fill; i++) begin
          win_vals[i] = win_vals[i + 1];
          win_ages[i] = win_ages[i + 1];
        end
        win_fill--;
      end else begin
        win_fill = k - 1;
      end
    end
    for (i = 0; i < win_fill; i++) win_ages[i] = win_ages[i] + 4'd1;
    // equal values go after the ones already held
    pos = 0;
    while (pos < win_fill && (win_vals[pos] <= smp)) pos++;
    for (i = win_fill; i > pos; i--) begin
      win_vals[i] = win_vals[i - 1];
      win_ages[i] = win_ages[i - 1];
    end
    win_vals[pos] = smp;
    win_ages[pos] = '0;
    win_fill++;
    if (win_fill == k) begin
      med = win_vals[(k + 1) / 2 - 1];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int draw_wait();
    if (no_idle) return 0;
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [31:0] draw_sample();
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      3, 4: return $unsigned($signed($urandom_range(0, 7)) - 4);
      5: return S_NEG1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(input bit do_cfg, input logic [WS_W-1:0] cfg_val,
                         input logic [31:0] smp, input bit new_seq,
                         input bit typed, input logic [31:0] known_med);
    stim_row_t r;
    r.do_cfg = do_cfg;
    r.cfg_val = cfg_val;
    r.smp = smp;
    r.new_seq = new_seq;
    r.typed = typed;
    r.known_med = known_med;
    directed_rows = {directed_rows, r};
  endtask

  // wait for the filter to go quiet, then write window_size
  task automatic write_window_size(input logic [WS_W-1:0] val);
    s_tvalid <= 1'b0;
    while (expected_medians.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wdata <= val;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_size_reg = val;
    clear_window();
    n_settings++;
  endtask

  // send one request and record the median it should produce
  task automatic send_sample(input logic [31:0] smp, input bit new_seq,
                             input bit typed, input logic [31:0] known_med);
    int gap;
    logic [31:0] med;
    gap = draw_wait();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= smp;
    s_tuser <= new_seq;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_samples++;
    if (slide_window(smp, new_seq, med)) begin
      expected_medians.insert(expected_medians.size(), typed ? known_med : med);
    end
  endtask

  // result side
  initial begin
    int gap;
    logic [31:0] want;
    wait (!rst);
    forever begin
      gap = draw_wait();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      if (expected_medians.size() == 0) begin
        $error("unexpected median %0d", $signed(m_tdata));
        errors++;
      end else begin
        want = expected_medians.pop_front();
        n_medians++;
        if (m_tdata !== want) begin
          $error("median mismatch: expected %0d, got %0d", $signed(want), $signed(m_tdata));
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [WS_W-1:0] ws;
    stim_row_t r;
    clear_window();

    // reset window of 3: extremes, refill after new_sequence, equal values
    add_row(0, 0, S_MAX, 0, 0, '0);
    add_row(0, 0, S_MIN, 0, 0, '0);
    add_row(0, 0, 32'd0, 0, 1, 32'd0);
    add_row(0, 0, S_MAX, 0, 1, 32'd0);
    add_row(0, 0, S_MIN, 0, 1, 32'd0);
    add_row(0, 0, 32'd5, 1, 0, '0);
    add_row(0, 0, 32'd5, 0, 0, '0);
    add_row(0, 0, 32'd5, 0, 1, 32'd5);
    add_row(0, 0, S_NEG1, 0, 0, '0);
    add_row(0, 0, S_NEG1, 0, 0, '0);
    add_row(0, 0, S_MIN, 1, 0, '0);
    add_row(0, 0, S_MIN, 0, 0, '0);
    add_row(0, 0, S_MIN, 0, 1, S_MIN);
    add_row(0, 0, 32'h1234_5678, 0, 0, '0);
    add_row(0, 0, 32'hEDCB_A987, 0, 0, '0);
    // size zero acts as a single-sample window
    add_row(1, 5'd0, S_MAX, 0, 1, S_MAX);
    add_row(0, 0, S_MIN, 0, 1, S_MIN);
    // window of two gives the smaller sample
    add_row(1, 5'd2, 32'd10, 0, 0, '0);
    add_row(0, 0, 32'hFFFF_FFFD, 0, 1, 32'hFFFF_FFFD);
    add_row(0, 0, 32'd7, 0, 1, 32'hFFFF_FFFD);
    add_row(0, 0, 32'h1234_5678, 0, 1, 32'd7);
    add_row(0, 0, 32'd9, 1, 0, '0);
    add_row(0, 0, 32'd9, 0, 1, 32'd9);
    add_row(1, 5'd1, 32'd42, 0, 1, 32'd42);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.do_cfg) write_window_size(r.cfg_val);
      send_sample(r.smp, r.new_seq, r.typed, r.known_med);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: ws = 5'd16;
        1: ws = 5'd31;
        2: ws = 5'd0;
        3: ws = 5'd1;
        4: ws = 5'd2;
        5: ws = 5'd17;
        6: ws = 5'd5;
        7: ws = 5'd8;
        8: ws = 5'd3;
        default: ws = WS_W'($urandom_range(0, 31));
      endcase
      write_window_size(ws);
      // some phases run back to back with no idling
      no_idle = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        send_sample(draw_sample(), $urandom_range(0, 39) == 0, 1'b0, '0);
      end
      no_idle = 1'b0;
    end

    s_tvalid <= 1'b0;
    while (expected_medians.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d samples, checked %0d medians", n_samples, n_medians);
    $display("covered %0d window_size writes including 0, 1, 2, 16 and saturating values",
             n_settings);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
